/* rtl/dsd_pkg.sv */
// shared types and constants for the date subtract block
package dsd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 16;
  localparam int COUNT_W = 16;
  // running day value: holds day minus count, signed
  localparam int CUR_W   = 18;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 16'd1582;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic check;
    logic step;
  } dsd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic date_ok;
    logic cur_pos;
  } dsd_stat_t;

endpackage

/* rtl/dsd_dp.sv */
// datapath: operand registers, year mod 25, validation and month step-back
module dsd_dp (
  input  logic                          clk,
  input  dsd_pkg::dsd_cmd_t             cmd,
  input  logic [dsd_pkg::DAY_W-1:0]     in_day,
  input  logic [dsd_pkg::MONTH_W-1:0]   in_month,
  input  logic [dsd_pkg::YEAR_W-1:0]    in_year,
  input  logic [dsd_pkg::COUNT_W-1:0]   in_days_back,
  output dsd_pkg::dsd_stat_t            stat,
  output logic [dsd_pkg::DAY_W-1:0]     res_day,
  output logic [dsd_pkg::MONTH_W-1:0]   res_month,
  output logic [dsd_pkg::YEAR_W-1:0]    res_year,
  output logic                          res_ok
);
  import dsd_pkg::*;

  // floor(y / 25) = (y * RECIP25) >> RECIP_SH, exact for 16-bit y
  localparam int RECIP_SH = 21;
  localparam logic [16:0] RECIP25 = 17'd83887;
  localparam logic [YEAR_W-1:0] DIV25 = 16'd25;
  localparam logic [4:0] R25_TOP = 5'd24;

  logic [DAY_W-1:0]   d_r;
  logic [MONTH_W-1:0] m_r, m_nxt;
  logic [YEAR_W-1:0]  y_r, y_nxt;
  logic [COUNT_W-1:0] n_r;
  logic [11:0]        q_r;
  logic [4:0]         r25_r, r25_nxt;
  logic signed [CUR_W-1:0] cur_r;
  logic               ok_r;

  logic [32:0]        prod;
  logic [YEAR_W-1:0]  q25;
  logic [YEAR_W-1:0]  rem;
  logic [DAY_W-1:0]   len_cur, len_nxt;
  logic               ok_now;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y,
                                                 input logic [4:0] r25);
    logic leap;
    leap = (y[1:0] == 2'b00) && ((r25 != 5'd0) || (y[3:0] == 4'd0));
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      MONTH_FEB: month_len = leap ? 5'd29 : 5'd28;
      default:   month_len = 5'd30;
    endcase
  endfunction

  assign prod = y_r * RECIP25;
  assign q25  = {4'b0, q_r} * DIV25;
  assign rem  = y_r - q25;

  assign len_cur = month_len(m_r, y_r, r25_r);
  assign ok_now  = (m_r >= MONTH_JAN) && (m_r <= MONTH_DEC) && (y_r >= YEAR_MIN) &&
                   (d_r != '0) && (d_r <= len_cur);

  // previous month, wrapping to december of the prior year
  always_comb begin
    if (m_r <= MONTH_JAN) begin
      m_nxt   = MONTH_DEC;
      y_nxt   = y_r - 16'd1;
      r25_nxt = (r25_r == 5'd0) ? R25_TOP : r25_r - 5'd1;
    end else begin
      m_nxt   = m_r - 4'd1;
      y_nxt   = y_r;
      r25_nxt = r25_r;
    end
  end

  assign len_nxt = month_len(m_nxt, y_nxt, r25_nxt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r <= in_day;
      m_r <= in_month;
      y_r <= in_year;
      n_r <= in_days_back;
    end
    if (cmd.div) begin
      q_r <= prod[32:RECIP_SH];
    end
    if (cmd.rem) begin
      r25_r <= rem[4:0];
    end
    if (cmd.check) begin
      ok_r  <= ok_now;
      cur_r <= $signed({13'b0, d_r}) - $signed({2'b0, n_r});
    end
    if (cmd.step) begin
      m_r   <= m_nxt;
      y_r   <= y_nxt;
      r25_r <= r25_nxt;
      cur_r <= cur_r + $signed({13'b0, len_nxt});
    end
  end

  assign stat.date_ok = ok_now;
  assign stat.cur_pos = !cur_r[CUR_W-1] && (cur_r != '0);

  assign res_ok    = ok_r;
  assign res_day   = ok_r ? cur_r[DAY_W-1:0] : '0;
  assign res_month = ok_r ? m_r : '0;
  assign res_year  = ok_r ? y_r : '0;

  a_step_only_below_one: assert property (@(posedge clk)
    cmd.step |-> !stat.cur_pos)
    else $error("month step while day already positive");

  a_step_month_range: assert property (@(posedge clk)
    cmd.step |=> (m_r >= MONTH_JAN) && (m_r <= MONTH_DEC))
    else $error("month out of range after step");

  a_step_day_bound: assert property (@(posedge clk)
    cmd.step |=> (cur_r <= $signed(18'd31)))
    else $error("running day above 31 after step");

endmodule

/* rtl/dsd_ctrl.sv */
// controller state machine: sequences load, year divide, remainder, validation and month steps
module dsd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  dsd_pkg::dsd_stat_t stat,
  output dsd_pkg::dsd_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);
  import dsd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_REM   = 6'b000100,
    S_CHECK = 6'b001000,
    S_STEP  = 6'b010000,
    S_DONE  = 6'b100000
  } dsd_state_t;

  dsd_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = stat.date_ok ? S_STEP : S_DONE;
      end
      S_STEP: begin
        if (stat.cur_pos) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.load)
    else $error("operands reloaded while busy");

endmodule

/* rtl/date_subtract_days.sv */
// top level: gregorian date minus a count of days
// sequence: operands load on the accept edge, then year divide, remainder and validation;
//   valid dates then step back one month per cycle, invalid ones go to the result beat
// throughput: one item at a time, the next start is taken the cycle after the strobe
// the month step-back loop in the datapath sets how long a valid date takes
// reset: synchronous active-low rst_n returns the controller to idle, busy low
// the result beat shows for one cycle on out_valid and cannot be stalled
module date_subtract_days (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [dsd_pkg::DAY_W-1:0]   in_day,
  input  logic [dsd_pkg::MONTH_W-1:0] in_month,
  input  logic [dsd_pkg::YEAR_W-1:0]  in_year,
  input  logic [dsd_pkg::COUNT_W-1:0] in_days_back,
  output logic                        out_valid,
  output logic [dsd_pkg::DAY_W-1:0]   out_day,
  output logic [dsd_pkg::MONTH_W-1:0] out_month,
  output logic [dsd_pkg::YEAR_W-1:0]  out_year,
  output logic                        out_date_valid
);
  import dsd_pkg::*;

  // command and status between controller and datapath
  dsd_cmd_t  cmd;
  dsd_stat_t stat;

  // controller: idle, year divide, remainder, validate, month steps, result beat
  dsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: operands load on the accept edge, results held until the next start is accepted
  dsd_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .in_day       (in_day),
    .in_month     (in_month),
    .in_year      (in_year),
    .in_days_back (in_days_back),
    .stat         (stat),
    .res_day      (out_day),
    .res_month    (out_month),
    .res_year     (out_year),
    .res_ok       (out_date_valid)
  );

  // invalid start dates give all-zero fields with the flag cleared
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_date_valid |-> (out_day == '0) && (out_month == '0) && (out_year == '0))
    else $error("invalid date beat carries nonzero fields");

  a_valid_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_valid |-> (out_day != '0) && (out_month != '0))
    else $error("valid date beat with zero day or month");

  // 65535 days back from the first day of 1582 lands in mid 1402
  a_valid_year_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_valid |-> (out_year >= 16'd1402))
    else $error("result year below reachable floor");

endmodule

/* dv/tb.sv */
// testbench for the gregorian date minus days block: directed and random dates against a predictor
`timescale 1ns / 1ps

module tb;
  import dsd_pkg::*;

  // one start beat as the sender drives it
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [COUNT_W-1:0] days_back;
  } date_cmd_t;

  // one result beat as the block shows it
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               valid;
  } date_res_t;

  // holds the dates the block still owes and checks each strobe against the oldest
  class date_scoreboard;
    date_res_t   pending_dates[$];
    int unsigned errors;
    int unsigned n_valid;
    int unsigned n_rejected;
    int unsigned n_checked;
    int unsigned deepest_back;

    function new();
      errors       = 0;
      n_valid      = 0;
      n_rejected   = 0;
      n_checked    = 0;
      deepest_back = 0;
    endfunction

    // month length with the 4 / 100 / 400 leap rule
    static function int unsigned days_in_month(int unsigned m, int unsigned y);
      bit leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        MONTH_FEB: return leap ? 29 : 28;
        default: return 30;
      endcase
    endfunction

    // expected result: reject bad dates, else walk back one month at a time
    function date_res_t earlier_date(date_cmd_t c);
      date_res_t   r;
      int          cur;
      int unsigned m;
      int unsigned y;
      r = '0;
      m = 32'(c.month);
      y = 32'(c.year);
      if (m < MONTH_JAN || m > MONTH_DEC || y < YEAR_MIN || c.day == 0 ||
          c.day > days_in_month(m, y))
        return r;
      cur = int'(c.day) - int'(c.days_back);
      while (cur < 1) begin
        if (m <= MONTH_JAN) begin
          m = 32'(MONTH_DEC);
          y = y - 1;
        end else begin
          m = m - 1;
        end
        cur += days_in_month(m, y);
      end
      r.day   = cur[DAY_W-1:0];
      r.month = m[MONTH_W-1:0];
      r.year  = y[YEAR_W-1:0];
      r.valid = 1'b1;
      return r;
    endfunction

    function void note_start(date_cmd_t c);
      date_res_t want;
      want = earlier_date(c);
      pending_dates.push_back(want);
      if (want.valid) n_valid++;
      else n_rejected++;
      if (want.valid && c.days_back > deepest_back) deepest_back = 32'(c.days_back);
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_date(date_res_t got);
      date_res_t want;
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d-%0d-%0d valid %0b",
                 $time, got.year, got.month, got.day, got.valid);
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      n_checked++;
      field_check("out_day", 32'(want.day), 32'(got.day));
      field_check("out_month", 32'(want.month), 32'(got.month));
      field_check("out_year", 32'(want.year), 32'(got.year));
      field_check("out_date_valid", 32'(want.valid), 32'(got.valid));
    endfunction
  endclass

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               start        = 1'b0;
  logic [DAY_W-1:0]   in_day       = '0;
  logic [MONTH_W-1:0] in_month     = '0;
  logic [YEAR_W-1:0]  in_year      = '0;
  logic [COUNT_W-1:0] in_days_back = '0;
  logic               busy;
  logic               out_valid;
  logic [DAY_W-1:0]   out_day;
  logic [MONTH_W-1:0] out_month;
  logic [YEAR_W-1:0]  out_year;
  logic               out_date_valid;

  date_scoreboard sb = new();

  date_subtract_days i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_days_back   (in_days_back),
    .out_valid      (out_valid),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_date_valid (out_date_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: the strobe lasts one cycle and cannot be held off,
  // so every edge with out_valid high is a beat to check
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_date('{out_day, out_month, out_year, out_date_valid});
  end

  // drive one start beat after a random gap; returns on the accepting edge
  // so the caller's next assignment is the only one in that time step
  task automatic send_date(input date_cmd_t c);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_day       <= c.day;
    in_month     <= c.month;
    in_year      <= c.year;
    in_days_back <= c.days_back;
    // accepted at the first edge where busy was low
    do @(posedge clk); while (busy);
    sb.note_start(c);
  endtask

  // hold start low until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending_dates.size() != 0) @(posedge clk);
  endtask

  // well-formed date with random content, or a broken day, or plain noise
  function automatic date_cmd_t random_date();
    date_cmd_t   c;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      // mostly modern years, sometimes anywhere up to the top of the field
      c.year  = ($urandom_range(0, 9) < 7) ? YEAR_W'($urandom_range(1582, 2600))
                                           : YEAR_W'($urandom_range(1582, 65535));
      c.month = MONTH_W'($urandom_range(1, 12));
      len     = date_scoreboard::days_in_month(32'(c.month), 32'(c.year));
      // month ends and firsts are where the step-back turns over
      case ($urandom_range(0, 3))
        0: c.day = DAY_W'(len);
        1: c.day = 5'd1;
        default: c.day = DAY_W'($urandom_range(1, len));
      endcase
      case ($urandom_range(0, 15))
        0: c.days_back = COUNT_W'($urandom_range(0, 65535));
        1: c.days_back = COUNT_W'(c.day);
        2: c.days_back = COUNT_W'(c.day - 5'd1);
        default: c.days_back = COUNT_W'($urandom_range(0, 1200));
      endcase
    end else if (kind < 8) begin
      // day past the month end for the block to reject; in 31-day months it is 31 or wraps to 0
      c.year      = YEAR_W'($urandom_range(1582, 2600));
      c.month     = MONTH_W'($urandom_range(1, 12));
      len         = date_scoreboard::days_in_month(32'(c.month), 32'(c.year));
      c.day       = DAY_W'($urandom_range(len + 1, 31));
      c.days_back = COUNT_W'($urandom_range(0, 65535));
    end else begin
      // noise across every bit of every field
      c.day       = DAY_W'($urandom_range(0, 31));
      c.month     = MONTH_W'($urandom_range(0, 15));
      c.year      = YEAR_W'($urandom_range(0, 65535));
      c.days_back = ($urandom_range(0, 1) == 0) ? COUNT_W'($urandom_range(0, 65535))
                                                : COUNT_W'($urandom_range(0, 400));
    end
    return c;
  endfunction

  initial begin
    // directed list: field extremes, leap corners, year and month turnovers
    date_cmd_t directed[$];
    directed = '{
      '{5'd1,  4'd1,  16'd1582,  16'd0},      // earliest valid date, nothing taken off
      '{5'd1,  4'd1,  16'd1582,  16'd65535},  // result well before the first valid year
      '{5'd31, 4'd12, 16'd1581,  16'd1},      // year just below the minimum
      '{5'd0,  4'd6,  16'd2000,  16'd3},      // day zero
      '{5'd10, 4'd0,  16'd2000,  16'd3},      // month zero
      '{5'd10, 4'd13, 16'd2000,  16'd3},      // month just past december
      '{5'd31, 4'd15, 16'd65535, 16'd65535},  // every field all ones
      '{5'd31, 4'd4,  16'd2021,  16'd0},      // day 31 in a 30-day month
      '{5'd29, 4'd2,  16'd1900,  16'd0},      // century year that is not leap
      '{5'd29, 4'd2,  16'd2000,  16'd0},      // 400-year leap day
      '{5'd29, 4'd2,  16'd2024,  16'd10},     // ordinary leap day
      '{5'd29, 4'd2,  16'd2023,  16'd0},      // leap day in a common year
      '{5'd30, 4'd2,  16'd2000,  16'd0},      // day 30 in a leap february
      '{5'd1,  4'd3,  16'd2000,  16'd1},      // back into a leap february
      '{5'd1,  4'd3,  16'd1900,  16'd1},      // back into a common february
      '{5'd1,  4'd1,  16'd2000,  16'd1},      // across the year boundary
      '{5'd31, 4'd12, 16'd65535, 16'd0},      // top year, no count
      '{5'd31, 4'd12, 16'd65535, 16'd65535},  // top year, largest count
      '{5'd15, 4'd6,  16'd2024,  16'd15},     // count equal to the day
      '{5'd15, 4'd6,  16'd2024,  16'd14},     // count one short of the day
      '{5'd31, 4'd7,  16'd2024,  16'd366}     // a full leap year back
    };

    // reset held low from time zero, then released once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_date(directed[k]);
    // sender hold-off: nothing new until the block has caught up
    drain_results();

    for (int i = 0; i < 250; i++) begin
      if (i == 125) drain_results();
      // short bursts with no gaps now and then
      send_date(random_date());
    end
    start <= 1'b0;

    // wait out the owed results, then watch on for a stray strobe
    while (sb.pending_dates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results: %0d valid dates, %0d rejected",
             sb.n_checked, sb.n_valid, sb.n_rejected);
    $display("deepest valid subtraction was %0d days", sb.deepest_back);
    if (sb.errors == 0 && sb.pending_dates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog: far past the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout: expected results still owed %0d", sb.pending_dates.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
rtl/dsd_pkg.sv
rtl/dsd_dp.sv
rtl/dsd_ctrl.sv
rtl/date_subtract_days.sv
dv/tb.sv
